// ===== sv/dnd_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// dnd_pkg: shared types and constants of the DNS name decompressor
// Status codes, label constants and the controller/datapath interface.
// ---------------------------------------------------------------------------
package dnd_pkg;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BOUNDS = 2'd1;
  localparam logic [1:0] ST_JUMPS  = 2'd2;
  localparam logic [1:0] ST_LONG   = 2'd3;

  // item function codes
  localparam logic FUNC_WRITE      = 1'b0;
  localparam logic FUNC_DECOMPRESS = 1'b1;

  // label byte: top two bits set marks a compression pointer
  localparam logic [1:0] PTR_TAG  = 2'b11;
  localparam logic [7:0] DOT_CHAR = 8'h2e;

  // characters per result item
  localparam logic [3:0] CHUNK_MAX = 4'd8;

  // controller to datapath commands
  typedef struct packed {
    logic       write_byte;   // store one packet byte
    logic       start;        // load start offset and limit
    logic       step_zero;    // step over the terminating zero label
    logic       ptr_hi;       // take first pointer byte
    logic       ptr_jump;     // take second pointer byte and jump
    logic       label_begin;  // insert dot, load label length
    logic       copy_step;    // copy one label character
    logic       fin;          // compute consumed count, rewind name read
    logic       chunk_begin;  // start assembling a chunk
    logic       gather_step;  // put one character into the chunk
    logic       emit_ok;      // load output with a name chunk
    logic       emit_err;     // load output with an error item
    logic [1:0] err_code;
  } dnd_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic at_end;       // walk position at or past the limit
    logic len_zero;     // label byte is zero
    logic len_ptr;      // label byte is a pointer
    logic ptr_cut;      // second pointer byte past the limit
    logic label_cut;    // label characters run past the limit
    logic name_long;    // name would reach the name store size
    logic jumps_over;   // this jump exceeds the jump budget
    logic copy_last;    // last character of the label
    logic chunk_empty;  // no characters left for this chunk
    logic gather_last;  // last character of this chunk
    logic out_free;     // output register can take an item
    logic out_last;     // this chunk ends the name
  } dnd_stat_t;

endpackage
`default_nettype wire

// ===== sv/dns_name_decompressor.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// dns_name_decompressor: DNS compressed name expander
// Loads a packet one byte per item and expands names into 8-byte chunks.
// ---------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+--------------------------------------------
//  in      | in_valid/in_ready   | func, address, data_byte, packet_length
//  out     | out_valid/out_ready | name_chunk, chunk_bytes, last_chunk,
//          |                     | status, name_length, bytes_consumed
//
// A byte write is stored as it is accepted. A decompress loads its start,
// walks each label header or pointer and copies each label character (one
// packet store read port), finishes, then gathers each chunk character by
// character (one name store read port). One item is worked at a time.
// Reset clears the controller and output valid; store contents stay as is.
// A stalled output holds the block once the next chunk is ready; the input
// reopens as soon as the last item of a name sits in the output register.
// ---------------------------------------------------------------------------
module dns_name_decompressor #(
  parameter int PACKET_BYTES = 4096,
  parameter int NAME_BYTES   = 256,
  parameter int MAX_JUMPS    = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        func,
  input  wire logic [11:0] address,
  input  wire logic [7:0]  data_byte,
  input  wire logic [12:0] packet_length,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      name_chunk,
  output logic [3:0]       chunk_bytes,
  output logic             last_chunk,
  output logic [1:0]       status,
  output logic [7:0]       name_length,
  output logic [12:0]      bytes_consumed
);
  import dnd_pkg::*;

  dnd_cmd_t  cmd;
  dnd_stat_t stat;

  // sequencing
  dnd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .func     (func),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // stores and registers
  dnd_datapath #(
    .PACKET_BYTES (PACKET_BYTES),
    .NAME_BYTES   (NAME_BYTES),
    .MAX_JUMPS    (MAX_JUMPS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .address        (address),
    .data_byte      (data_byte),
    .packet_length  (packet_length),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .name_chunk     (name_chunk),
    .chunk_bytes    (chunk_bytes),
    .last_chunk     (last_chunk),
    .status         (status),
    .name_length    (name_length),
    .bytes_consumed (bytes_consumed)
  );

endmodule
`default_nettype wire

// ===== sv/dnd_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// dnd_ctrl: sequencing controller
// Walks labels and pointers, then chunks the name out, driving the datapath.
// ---------------------------------------------------------------------------
module dnd_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               func,
  output logic                    in_ready,
  input  wire dnd_pkg::dnd_stat_t stat,
  output dnd_pkg::dnd_cmd_t       cmd
);
  import dnd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LEN,
    S_PTR,
    S_COPY,
    S_FIN,
    S_CHUNK,
    S_GATHER,
    S_EMIT,
    S_ERR
  } state_t;

  state_t     state, state_next;
  logic [1:0] err_code, err_code_next;

  // next state and commands
  always_comb begin
    state_next    = state;
    err_code_next = err_code;
    cmd           = '0;
    cmd.err_code  = err_code;
    in_ready      = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (func == FUNC_WRITE) begin
            cmd.write_byte = 1'b1;
          end else begin
            cmd.start  = 1'b1;
            state_next = S_LEN;
          end
        end
      end
      S_LEN: begin
        if (stat.at_end) begin
          err_code_next = ST_BOUNDS;
          state_next    = S_ERR;
        end else if (stat.len_zero) begin
          cmd.step_zero = 1'b1;
          state_next    = S_FIN;
        end else if (stat.len_ptr) begin
          if (stat.ptr_cut) begin
            err_code_next = ST_BOUNDS;
            state_next    = S_ERR;
          end else begin
            cmd.ptr_hi = 1'b1;
            state_next = S_PTR;
          end
        end else if (stat.label_cut) begin
          err_code_next = ST_BOUNDS;
          state_next    = S_ERR;
        end else if (stat.name_long) begin
          err_code_next = ST_LONG;
          state_next    = S_ERR;
        end else begin
          cmd.label_begin = 1'b1;
          state_next      = S_COPY;
        end
      end
      S_PTR: begin
        cmd.ptr_jump = 1'b1;
        if (stat.jumps_over) begin
          err_code_next = ST_JUMPS;
          state_next    = S_ERR;
        end else begin
          state_next = S_LEN;
        end
      end
      S_COPY: begin
        cmd.copy_step = 1'b1;
        if (stat.copy_last) begin
          state_next = S_LEN;
        end
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_CHUNK;
      end
      S_CHUNK: begin
        cmd.chunk_begin = 1'b1;
        state_next      = stat.chunk_empty ? S_EMIT : S_GATHER;
      end
      S_GATHER: begin
        cmd.gather_step = 1'b1;
        if (stat.gather_last) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_ok = 1'b1;
          state_next  = stat.out_last ? S_IDLE : S_CHUNK;
        end
      end
      S_ERR: begin
        if (stat.out_free) begin
          cmd.emit_err = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      err_code <= ST_OK;
    end else begin
      state    <= state_next;
      err_code <= err_code_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/dnd_datapath.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// dnd_datapath: packet store, name store, walk registers and output register
// Packet and name stores read one byte per cycle; read data is registered.
// ---------------------------------------------------------------------------
module dnd_datapath #(
  parameter int PACKET_BYTES = 4096,
  parameter int NAME_BYTES   = 256,
  parameter int MAX_JUMPS    = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dnd_pkg::dnd_cmd_t cmd,
  output dnd_pkg::dnd_stat_t     stat,
  input  wire logic [11:0]       address,
  input  wire logic [7:0]        data_byte,
  input  wire logic [12:0]       packet_length,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [63:0]            name_chunk,
  output logic [3:0]             chunk_bytes,
  output logic                   last_chunk,
  output logic [1:0]             status,
  output logic [7:0]             name_length,
  output logic [12:0]            bytes_consumed
);
  import dnd_pkg::*;

  localparam int AW = $clog2(PACKET_BYTES);       // packet index
  localparam int LW = $clog2(PACKET_BYTES + 1);   // limit
  localparam int PW = (LW > 14) ? LW : 14;        // walk position
  localparam int XW = PW + 2;                     // position arithmetic
  localparam int NW = $clog2(NAME_BYTES);         // name index
  localparam int BW = $clog2(NAME_BYTES + 1);     // built length
  localparam int JW = $clog2(MAX_JUMPS + 1);      // jump count

  // write address wrapped into the packet store
  function automatic logic [AW-1:0] wrap_addr(input logic [11:0] a);
    int unsigned r;
    r = 32'(a);
    for (int k = 2; k >= 0; k--) begin
      if (r >= (PACKET_BYTES << k)) begin
        r = r - (PACKET_BYTES << k);
      end
    end
    return AW'(r);
  endfunction

  logic [7:0]    pkt_mem [PACKET_BYTES];
  logic [7:0]    name_mem [NAME_BYTES];

  logic [7:0]    rdata;       // packet byte at walk
  logic [7:0]    nrd;         // name byte at nptr
  logic [PW-1:0] walk, walk_next;
  logic [LW-1:0] limit;
  logic [11:0]   start;
  logic [PW-1:0] ret;
  logic          jumped;
  logic [JW-1:0] jumps;
  logic [5:0]    hi;
  logic [BW-1:0] built;
  logic [7:0]    lrem;
  logic [12:0]   consumed;
  logic [7:0]    nlen;
  logic [NW-1:0] nptr, nptr_next;
  logic [7:0]    nrem;
  logic [3:0]    cnt;
  logic [2:0]    lane;
  logic [63:0]   chunk;

  logic [XW-1:0] walk_x, lim_x, len_x;
  logic [BW:0]   b2;

  // bounds and length checks
  always_comb begin
    walk_x           = XW'(walk);
    lim_x            = XW'(limit);
    len_x            = XW'(rdata);
    b2               = (BW+1)'(built) + (BW+1)'(built != '0);
    stat.at_end      = walk_x >= lim_x;
    stat.len_zero    = rdata == 8'h00;
    stat.len_ptr     = rdata[7:6] == PTR_TAG;
    stat.ptr_cut     = (walk_x + XW'(1)) >= lim_x;
    stat.label_cut   = (walk_x + XW'(1) + len_x) > lim_x;
    stat.name_long   = ((BW+2)'(b2) + (BW+2)'(rdata)) >= (BW+2)'(NAME_BYTES);
    stat.jumps_over  = ((JW+1)'(jumps) + (JW+1)'(1)) > (JW+1)'(MAX_JUMPS);
    stat.copy_last   = lrem == 8'd1;
    stat.chunk_empty = nrem == 8'd0;
    stat.gather_last = ({1'b0, lane} + 4'd1) == cnt;
    stat.out_free    = !out_valid || out_ready;
    stat.out_last    = nrem <= 8'(CHUNK_MAX);
  end

  // next walk position, also the packet read address
  always_comb begin
    walk_next = walk;
    if (cmd.start) begin
      walk_next = PW'(address);
    end else if (cmd.ptr_jump) begin
      walk_next = PW'({hi, rdata});
    end else if (cmd.step_zero || cmd.ptr_hi || cmd.label_begin || cmd.copy_step) begin
      walk_next = walk + PW'(1);
    end
  end

  // next name read pointer
  always_comb begin
    nptr_next = nptr;
    if (cmd.fin) begin
      nptr_next = '0;
    end else if (cmd.gather_step) begin
      nptr_next = nptr + NW'(1);
    end
  end

  // packet store
  always_ff @(posedge clk) begin
    if (cmd.write_byte) begin
      pkt_mem[wrap_addr(address)] <= data_byte;
    end
    rdata <= pkt_mem[walk_next[AW-1:0]];
  end

  // name store: dots and label characters written at the built length
  always_ff @(posedge clk) begin
    if (cmd.copy_step) begin
      name_mem[built[NW-1:0]] <= rdata;
    end else if (cmd.label_begin && built != '0) begin
      name_mem[built[NW-1:0]] <= DOT_CHAR;
    end
    nrd <= name_mem[nptr_next];
  end

  // walk registers
  always_ff @(posedge clk) begin
    walk <= walk_next;
    nptr <= nptr_next;
    if (cmd.start) begin
      start  <= address;
      limit  <= (32'(packet_length) > PACKET_BYTES) ? LW'(PACKET_BYTES)
                                                     : LW'(packet_length);
      jumps  <= '0;
      built  <= '0;
      jumped <= 1'b0;
    end
    if (cmd.ptr_hi) begin
      hi <= rdata[5:0];
      if (!jumped) begin
        jumped <= 1'b1;
        ret    <= walk + PW'(2);
      end
    end
    if (cmd.ptr_jump) begin
      jumps <= jumps + JW'(1);
    end
    if (cmd.label_begin) begin
      built <= b2[BW-1:0];
      lrem  <= rdata;
    end
    if (cmd.copy_step) begin
      built <= built + BW'(1);
      lrem  <= lrem - 8'd1;
    end
    if (cmd.fin) begin
      consumed <= jumped ? 13'(ret - PW'(start)) : 13'(walk - PW'(start));
      nlen     <= 8'(built);
      nrem     <= 8'(built);
    end
    if (cmd.chunk_begin) begin
      cnt   <= (nrem > 8'(CHUNK_MAX)) ? CHUNK_MAX : nrem[3:0];
      lane  <= '0;
      chunk <= '0;
    end
    if (cmd.gather_step) begin
      chunk[8*lane +: 8] <= nrd;
      lane               <= lane + 3'd1;
    end
    if (cmd.emit_ok) begin
      nrem <= nrem - 8'(cnt);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_ok || cmd.emit_err) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit_ok) begin
      name_chunk     <= chunk;
      chunk_bytes    <= cnt;
      last_chunk     <= stat.out_last;
      status         <= ST_OK;
      name_length    <= nlen;
      bytes_consumed <= consumed;
    end else if (cmd.emit_err) begin
      name_chunk     <= '0;
      chunk_bytes    <= '0;
      last_chunk     <= 1'b1;
      status         <= cmd.err_code;
      name_length    <= '0;
      bytes_consumed <= '0;
    end
  end

endmodule
`default_nettype wire

// ===== sv/dnd_checker.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// dnd_checker: port-level checks of the DNS name decompressor
// Watches the result channel for item shape and stall behavior.
// ---------------------------------------------------------------------------
module dnd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        func,
  input wire logic [11:0] address,
  input wire logic [7:0]  data_byte,
  input wire logic [12:0] packet_length,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] name_chunk,
  input wire logic [3:0]  chunk_bytes,
  input wire logic        last_chunk,
  input wire logic [1:0]  status,
  input wire logic [7:0]  name_length,
  input wire logic [12:0] bytes_consumed
);
  import dnd_pkg::*;

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // a stalled item holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
      out_valid && !out_ready |=> out_valid && $stable(name_chunk) &&
      $stable(chunk_bytes) && $stable(last_chunk) && $stable(status))
    else $error("stalled output item changed");

  // an error is a single empty final item
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
      out_valid && status != ST_OK |-> last_chunk && chunk_bytes == 4'd0 &&
      name_chunk == 64'd0 && name_length == 8'd0 && bytes_consumed == 13'd0)
    else $error("malformed error item");

  // every chunk before the last is full
  a_full_chunk: assert property (@(posedge clk) disable iff (rst)
      out_valid && !last_chunk |-> chunk_bytes == CHUNK_MAX && status == ST_OK)
    else $error("short chunk before end of name");

endmodule

bind dns_name_decompressor dnd_checker u_dnd_checker (.*);
`default_nettype wire
